>>> sv/wave_header_parser_defines.svh
// ----------------------------------------------------------------------------
// wave_header_parser_defines
// Assertion macros shared by the RIFF/WAVE header parser RTL.
// ----------------------------------------------------------------------------
`ifndef WAVE_HEADER_PARSER_DEFINES_SVH
`define WAVE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define WHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define WHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg
// Transaction types and status codes of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_MISSING_RIFF = 2'd1;
    localparam logic [1:0] STATUS_MISSING_WAVE = 2'd2;
    localparam logic [1:0] STATUS_NO_DATA      = 2'd3;

    // Chunk tags as little-endian words, and accepted fmt codes
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [15:0] FMT_PCM  = 16'h0001;
    localparam logic [15:0] FMT_EXT  = 16'hFFFE;

    // One input transaction: a single header byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } whp_in_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] riff_size;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_size;
        logic [31:0] data_offset;
    } whp_out_t;

endpackage

>>> sv/whp_core.sv
// ----------------------------------------------------------------------------
// whp_core
// Parse state machine: consumes one byte per step, assembles little-endian
// fields, walks the chunk list and raises at most one result per byte.
// ----------------------------------------------------------------------------
module whp_core
    import whp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  whp_in_t  in_item,
    output logic     res_valid,
    output whp_out_t res_item
);

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CSIZE,
        PH_FFMT, PH_FCH, PH_FRATE, PH_FBRATE, PH_FALIGN, PH_FBITS, PH_SKIP
    } phase_t;

    localparam logic [32:0] POS_MAX  = {33{1'b1}};

    phase_t      phase_reg, phase_next, cur_phase;
    logic [32:0] pos_reg, pos_next, cur_pos;
    logic [2:0]  cnt_reg, cnt_next, cur_cnt, cnt_inc;
    logic [31:0] word_reg, word_next, cur_word, word_acc;
    logic [31:0] riff_reg, riff_next, cur_riff;
    logic [31:0] tag_reg, tag_next, cur_tag;
    logic [31:0] skip_reg, skip_next, cur_skip, skip_dec;
    logic [15:0] fmt_reg, fmt_next, cur_fmt;
    logic [15:0] chan_reg, chan_next, cur_chan;
    logic [31:0] rate_reg, rate_next, cur_rate;
    logic [31:0] brate_reg, brate_next, cur_brate;
    logic [15:0] align_reg, align_next, cur_align;
    logic [15:0] bits_reg, bits_next, cur_bits;
    logic        done_reg, done_next, cur_done;
    logic        in_body, field_done, end_chunk, emit;
    logic [2:0]  field_len;
    logic [1:0]  status;
    logic [31:0] dsize, doff;
    logic [33:0] riff_end;

    // Select current state; start of file clears everything first
    always_comb begin
        if (in_item.start_of_file) begin
            cur_phase = PH_RIFF;
            cur_pos   = '0;
            cur_cnt   = '0;
            cur_word  = '0;
            cur_riff  = '0;
            cur_tag   = '0;
            cur_skip  = '0;
            cur_fmt   = '0;
            cur_chan  = '0;
            cur_rate  = '0;
            cur_brate = '0;
            cur_align = '0;
            cur_bits  = '0;
            cur_done  = 1'b0;
        end else begin
            cur_phase = phase_reg;
            cur_pos   = pos_reg;
            cur_cnt   = cnt_reg;
            cur_word  = word_reg;
            cur_riff  = riff_reg;
            cur_tag   = tag_reg;
            cur_skip  = skip_reg;
            cur_fmt   = fmt_reg;
            cur_chan  = chan_reg;
            cur_rate  = rate_reg;
            cur_brate = brate_reg;
            cur_align = align_reg;
            cur_bits  = bits_reg;
            cur_done  = done_reg;
        end
    end

    // Per-byte datapath pieces
    assign in_body   = cur_phase inside {[PH_FFMT:PH_SKIP]};
    assign skip_dec  = (in_body && cur_skip != '0) ? cur_skip - 32'd1 : cur_skip;
    assign word_acc  = cur_word | ({24'd0, in_item.data_byte} << {cur_cnt[1:0], 3'b000});
    assign cnt_inc   = cur_cnt + 3'd1;
    assign field_len = (cur_phase inside {PH_FFMT, PH_FCH, PH_FALIGN, PH_FBITS}) ? 3'd2 : 3'd4;
    assign field_done = cnt_inc >= field_len;
    assign riff_end  = {2'b00, cur_riff} + 34'd8;

    // Next state and result
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        riff_next  = riff_reg;
        tag_next   = tag_reg;
        skip_next  = skip_reg;
        fmt_next   = fmt_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        brate_next = brate_reg;
        align_next = align_reg;
        bits_next  = bits_reg;
        done_next  = done_reg;
        end_chunk  = 1'b0;
        emit       = 1'b0;
        status     = STATUS_OK;
        dsize      = '0;
        doff       = '0;
        if (step) begin
            phase_next = cur_phase;
            pos_next   = cur_pos;
            cnt_next   = cur_cnt;
            word_next  = cur_word;
            riff_next  = cur_riff;
            tag_next   = cur_tag;
            skip_next  = cur_skip;
            fmt_next   = cur_fmt;
            chan_next  = cur_chan;
            rate_next  = cur_rate;
            brate_next = cur_brate;
            align_next = cur_align;
            bits_next  = cur_bits;
            done_next  = cur_done;
            if (!cur_done) begin
                pos_next  = (cur_pos == POS_MAX) ? cur_pos : cur_pos + 33'd1;
                skip_next = skip_dec;
                if (cur_phase == PH_SKIP) begin
                    end_chunk = (skip_dec == '0);
                end else if (!field_done) begin
                    // Field still partial: accumulate, or stop at chunk end
                    word_next = word_acc;
                    cnt_next  = cnt_inc;
                    end_chunk = in_body && (skip_dec == '0);
                end else begin
                    word_next = '0;
                    cnt_next  = '0;
                    case (cur_phase)
                        PH_RIFF: begin
                            if (word_acc != TAG_RIFF) begin
                                emit   = 1'b1;
                                status = STATUS_MISSING_RIFF;
                            end else begin
                                phase_next = PH_RSIZE;
                            end
                        end
                        PH_RSIZE: begin
                            riff_next  = word_acc;
                            phase_next = PH_WAVE;
                        end
                        PH_WAVE: begin
                            if (word_acc != TAG_WAVE) begin
                                emit   = 1'b1;
                                status = STATUS_MISSING_WAVE;
                            end else begin
                                phase_next = PH_CTAG;
                            end
                        end
                        PH_CTAG: begin
                            tag_next   = word_acc;
                            phase_next = PH_CSIZE;
                        end
                        PH_CSIZE: begin
                            if (cur_tag == TAG_DATA) begin
                                emit   = 1'b1;
                                status = STATUS_OK;
                                dsize  = word_acc;
                                doff   = pos_next[31:0];
                            end else begin
                                skip_next  = word_acc;
                                phase_next = (cur_tag == TAG_FMT) ? PH_FFMT : PH_SKIP;
                                end_chunk  = (word_acc == '0);
                            end
                        end
                        PH_FFMT: begin
                            fmt_next   = word_acc[15:0];
                            phase_next = (word_acc[15:0] == FMT_PCM ||
                                          word_acc[15:0] == FMT_EXT) ? PH_FCH : PH_SKIP;
                            end_chunk  = (skip_dec == '0);
                        end
                        PH_FCH: begin
                            chan_next  = word_acc[15:0];
                            phase_next = PH_FRATE;
                            end_chunk  = (skip_dec == '0);
                        end
                        PH_FRATE: begin
                            rate_next  = word_acc;
                            phase_next = PH_FBRATE;
                            end_chunk  = (skip_dec == '0);
                        end
                        PH_FBRATE: begin
                            brate_next = word_acc;
                            phase_next = PH_FALIGN;
                            end_chunk  = (skip_dec == '0);
                        end
                        PH_FALIGN: begin
                            align_next = word_acc[15:0];
                            phase_next = PH_FBITS;
                            end_chunk  = (skip_dec == '0);
                        end
                        default: begin
                            bits_next  = word_acc[15:0];
                            phase_next = PH_SKIP;
                            end_chunk  = (skip_dec == '0);
                        end
                    endcase
                end
                // Close the chunk; stop if the RIFF size is used up
                if (end_chunk) begin
                    cnt_next  = '0;
                    word_next = '0;
                    if ({1'b0, pos_next} >= riff_end) begin
                        emit   = 1'b1;
                        status = STATUS_NO_DATA;
                    end else begin
                        phase_next = PH_CTAG;
                    end
                end
                if (emit) begin
                    done_next = 1'b1;
                end
            end
        end
    end

    // Result as seen after this byte's captures
    assign res_valid                = emit;
    assign res_item.status          = status;
    assign res_item.riff_size       = riff_next;
    assign res_item.audio_format    = fmt_next;
    assign res_item.channel_count   = chan_next;
    assign res_item.sample_rate     = rate_next;
    assign res_item.byte_rate       = brate_next;
    assign res_item.block_align     = align_next;
    assign res_item.bits_per_sample = bits_next;
    assign res_item.data_size       = dsize;
    assign res_item.data_offset     = doff;

    // Hold parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RIFF;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            word_reg  <= '0;
            riff_reg  <= '0;
            tag_reg   <= '0;
            skip_reg  <= '0;
            fmt_reg   <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            brate_reg <= '0;
            align_reg <= '0;
            bits_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            word_reg  <= word_next;
            riff_reg  <= riff_next;
            tag_reg   <= tag_next;
            skip_reg  <= skip_next;
            fmt_reg   <= fmt_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            brate_reg <= brate_next;
            align_reg <= align_next;
            bits_reg  <= bits_next;
            done_reg  <= done_next;
        end
    end

endmodule

>>> sv/wave_header_parser.sv
// ----------------------------------------------------------------------------
// wave_header_parser
// Byte-serial RIFF/WAVE header parser with a registered result channel.
// Throughput: one byte per cycle while the result channel is not stalled.
// Result path: the byte that completes a result loads it into the m_ output register.
// Rate is set by the single parse state update per byte in whp_core.
// Reset: synchronous active-low aresetn clears parse state and the result valid flag.
// ----------------------------------------------------------------------------
`include "wave_header_parser_defines.svh"

module wave_header_parser
    import whp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  whp_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output whp_out_t m_data
);

    logic     step;
    logic     res_valid;
    whp_out_t res_item;
    logic     m_valid_reg, m_valid_next;
    whp_out_t m_data_reg, m_data_next;

    // Accept while the result register is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    whp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // Load a new result or drop a delivered one
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (step && res_valid) begin
            m_valid_next = 1'b1;
            m_data_next  = res_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `WHP_ASSERT_NOW(a_err_no_data, m_valid && m_data.status != STATUS_OK, m_data.data_size == '0 && m_data.data_offset == '0, "error result carries data fields")
    `WHP_ASSERT_NOW(a_riff_zero, m_valid && m_data.status == STATUS_MISSING_RIFF, m_data.riff_size == '0, "missing RIFF result carries a size")
    `WHP_ASSERT_NEXT(a_result_held, step && res_valid, m_valid, "accepted result not presented")

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the RIFF/WAVE header parser. Byte streams of whole files,
// broken files and noise go in on the s_ channel; a local model of the parse
// predicts each header result and a checker compares every m_ transaction
// field by field. Both channels idle at random, and the result side also
// holds off once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_top
    import whp_pkg::*;
();

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [31:0] TAG_LIST     = 32'h5453494C;
    localparam logic [31:0] TAG_JUNK     = 32'h4B4E554A;

    typedef enum logic [3:0] {
        PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_TAG, PH_CHUNK_SIZE,
        PH_FMT_CODE, PH_FMT_CHANNELS, PH_FMT_RATE, PH_FMT_BYTE_RATE,
        PH_FMT_ALIGN, PH_FMT_BITS, PH_SKIP_BODY
    } phase_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    whp_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    whp_out_t m_data;

    // Parse model state
    phase_t      p_phase;
    logic [32:0] p_pos;
    logic [2:0]  p_count;
    logic [31:0] p_word;
    logic [31:0] p_riff;
    logic [31:0] p_tag;
    logic [31:0] p_skip;
    logic [15:0] p_fmt;
    logic [15:0] p_chan;
    logic [31:0] p_rate;
    logic [31:0] p_brate;
    logic [15:0] p_align;
    logic [15:0] p_bits;
    logic        p_done;

    whp_out_t expected_headers[$];
    whp_in_t  file_stream[$];

    int error_count  = 0;
    int items_sent   = 0;
    int cycle_count  = 0;
    bit no_idle      = 1'b0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    wave_header_parser u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL wave_header_parser");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Header parse model
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        p_phase = PH_RIFF_TAG;
        p_pos   = '0;
        p_count = '0;
        p_word  = '0;
        p_riff  = '0;
        p_tag   = '0;
        p_skip  = '0;
        p_fmt   = '0;
        p_chan  = '0;
        p_rate  = '0;
        p_brate = '0;
        p_align = '0;
        p_bits  = '0;
        p_done  = 1'b0;
    endfunction

    function automatic void finish_header(logic [1:0] status, logic [31:0] dsize,
                                          logic [31:0] doff);
        whp_out_t hdr;
        hdr.status          = status;
        hdr.riff_size       = p_riff;
        hdr.audio_format    = p_fmt;
        hdr.channel_count   = p_chan;
        hdr.sample_rate     = p_rate;
        hdr.byte_rate       = p_brate;
        hdr.block_align     = p_align;
        hdr.bits_per_sample = p_bits;
        hdr.data_size       = dsize;
        hdr.data_offset     = doff;
        expected_headers.push_back(hdr);
        p_done = 1'b1;
    endfunction

    // End of a chunk body: check the RIFF size, else look for the next tag
    function automatic void close_chunk();
        p_count = '0;
        p_word  = '0;
        if ({1'b0, p_pos} >= {2'b00, p_riff} + 34'd8)
            finish_header(STATUS_NO_DATA, '0, '0);
        else
            p_phase = PH_CHUNK_TAG;
    endfunction

    // Advance the model by one byte; return 1 if the byte was not ignored
    function automatic bit parse_byte(logic [7:0] b, logic sof);
        phase_t      ph;
        int          width;
        logic [31:0] v;
        if (sof)
            clear_parser();
        if (p_done)
            return 1'b0;
        if (p_pos != '1)
            p_pos = p_pos + 33'd1;
        ph = p_phase;
        if (ph >= PH_FMT_CODE && p_skip != 0)
            p_skip = p_skip - 32'd1;
        if (ph == PH_SKIP_BODY) begin
            if (p_skip == 0)
                close_chunk();
            return 1'b1;
        end
        p_word  = p_word | ({24'b0, b} << (8 * p_count[1:0]));
        p_count = p_count + 3'd1;
        width = (ph == PH_FMT_CODE || ph == PH_FMT_CHANNELS ||
                 ph == PH_FMT_ALIGN || ph == PH_FMT_BITS) ? 2 : 4;
        if (p_count < width) begin
            if (ph >= PH_FMT_CODE && p_skip == 0)
                close_chunk();
            return 1'b1;
        end
        v       = p_word;
        p_count = '0;
        p_word  = '0;
        case (ph)
            PH_RIFF_TAG: begin
                if (v != TAG_RIFF)
                    finish_header(STATUS_MISSING_RIFF, '0, '0);
                else
                    p_phase = PH_RIFF_SIZE;
                return 1'b1;
            end
            PH_RIFF_SIZE: begin
                p_riff  = v;
                p_phase = PH_WAVE_TAG;
                return 1'b1;
            end
            PH_WAVE_TAG: begin
                if (v != TAG_WAVE)
                    finish_header(STATUS_MISSING_WAVE, '0, '0);
                else
                    p_phase = PH_CHUNK_TAG;
                return 1'b1;
            end
            PH_CHUNK_TAG: begin
                p_tag   = v;
                p_phase = PH_CHUNK_SIZE;
                return 1'b1;
            end
            PH_CHUNK_SIZE: begin
                if (p_tag == TAG_DATA) begin
                    finish_header(STATUS_OK, v, p_pos[31:0]);
                    return 1'b1;
                end
                p_skip  = v;
                p_phase = (p_tag == TAG_FMT) ? PH_FMT_CODE : PH_SKIP_BODY;
                if (v == 0)
                    close_chunk();
                return 1'b1;
            end
            PH_FMT_CODE: begin
                p_fmt   = v[15:0];
                p_phase = (p_fmt == FMT_PCM || p_fmt == FMT_EXT) ? PH_FMT_CHANNELS
                                                                 : PH_SKIP_BODY;
            end
            PH_FMT_CHANNELS: begin
                p_chan  = v[15:0];
                p_phase = PH_FMT_RATE;
            end
            PH_FMT_RATE: begin
                p_rate  = v;
                p_phase = PH_FMT_BYTE_RATE;
            end
            PH_FMT_BYTE_RATE: begin
                p_brate = v;
                p_phase = PH_FMT_ALIGN;
            end
            PH_FMT_ALIGN: begin
                p_align = v[15:0];
                p_phase = PH_FMT_BITS;
            end
            default: begin
                p_bits  = v[15:0];
                p_phase = PH_SKIP_BODY;
            end
        endcase
        if (p_skip == 0)
            close_chunk();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Compare each result transaction with the oldest expected header
    always @(posedge aclk) begin : result_checker
        whp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_headers.size() == 0) begin
                report_mismatch("unexpected result", {30'b0, m_data.status}, '0);
            end else begin
                want = expected_headers.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", {30'b0, m_data.status}, {30'b0, want.status});
                if (m_data.riff_size !== want.riff_size)
                    report_mismatch("riff_size", m_data.riff_size, want.riff_size);
                if (m_data.audio_format !== want.audio_format)
                    report_mismatch("audio_format", {16'b0, m_data.audio_format},
                                    {16'b0, want.audio_format});
                if (m_data.channel_count !== want.channel_count)
                    report_mismatch("channel_count", {16'b0, m_data.channel_count},
                                    {16'b0, want.channel_count});
                if (m_data.sample_rate !== want.sample_rate)
                    report_mismatch("sample_rate", m_data.sample_rate, want.sample_rate);
                if (m_data.byte_rate !== want.byte_rate)
                    report_mismatch("byte_rate", m_data.byte_rate, want.byte_rate);
                if (m_data.block_align !== want.block_align)
                    report_mismatch("block_align", {16'b0, m_data.block_align},
                                    {16'b0, want.block_align});
                if (m_data.bits_per_sample !== want.bits_per_sample)
                    report_mismatch("bits_per_sample", {16'b0, m_data.bits_per_sample},
                                    {16'b0, want.bits_per_sample});
                if (m_data.data_size !== want.data_size)
                    report_mismatch("data_size", m_data.data_size, want.data_size);
                if (m_data.data_offset !== want.data_offset)
                    report_mismatch("data_offset", m_data.data_offset, want.data_offset);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int burst;
        m_ready = 1'b0;
        burst   = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req && !long_hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_done = 1'b1;
                m_ready <= 1'b1;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else if (burst > 0) begin
                m_ready <= 1'b0;
                burst--;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Offer one byte and hold it until accepted; entered and left at a falling edge
    task automatic send_item(input whp_in_t item);
        int gap;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        void'(parse_byte(item.data_byte, item.start_of_file));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_stream();
        foreach (file_stream[i])
            send_item(file_stream[i]);
    endtask

    task automatic pause_sender();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Append a little-endian value; the first byte of a stream starts a file
    function automatic void push_le(logic [31:0] v, int n);
        whp_in_t item;
        for (int i = 0; i < n; i++) begin
            item.data_byte     = v[8 * i +: 8];
            item.start_of_file = (file_stream.size() == 0);
            file_stream.push_back(item);
        end
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Build one file: header, up to three fmt or other chunks, then the data chunk
    function automatic void build_wave_file();
        logic [127:0] fmt_le;
        logic [15:0]  code;
        logic [31:0]  size;
        logic [31:0]  riff;
        logic [31:0]  w_chan, w_rate, w_brate, w_align, w_bits;
        int           nchunks;
        file_stream.delete();
        push_le(TAG_RIFF, 4);
        push_le('0, 4);
        push_le(TAG_WAVE, 4);
        nchunks = $urandom_range(0, 3);
        for (int c = 0; c < nchunks; c++) begin
            if ($urandom_range(0, 9) < 5) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: code = FMT_PCM;
                    4, 5:       code = FMT_EXT;
                    6:          code = 16'h0000;
                    7:          code = 16'hFFFF;
                    default:    code = 16'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: size = 16;
                    5:             size = 18;
                    6, 7:          size = $urandom_range(0, 15);
                    default:       size = $urandom_range(17, 40);
                endcase
                w_bits  = pick_word();
                w_align = pick_word();
                w_brate = pick_word();
                w_rate  = pick_word();
                w_chan  = pick_word();
                fmt_le = {w_bits[15:0], w_align[15:0], w_brate, w_rate,
                          w_chan[15:0], code};
                push_le(TAG_FMT, 4);
                push_le(size, 4);
                for (int i = 0; i < size; i++)
                    push_le((i < 16) ? {24'b0, fmt_le[8 * i +: 8]} : $urandom, 1);
            end else begin
                case ($urandom_range(0, 3))
                    0:       push_le(TAG_LIST, 4);
                    1:       push_le(TAG_JUNK, 4);
                    default: push_le($urandom, 4);
                endcase
                size = $urandom_range(0, 21);
                push_le(size, 4);
                for (int i = 0; i < size; i++)
                    push_le($urandom, 1);
            end
        end
        push_le(TAG_DATA, 4);
        push_le(pick_word(), 4);
        // RIFF size: mostly ample, sometimes short enough to run out at a chunk end
        case ($urandom_range(0, 9))
            0, 1, 2: riff = $urandom_range(4, file_stream.size());
            3:       riff = 32'hFFFF_FFFF;
            4:       riff = 32'h0000_0000;
            default: riff = $urandom;
        endcase
        for (int i = 0; i < 4; i++)
            file_stream[4 + i].data_byte = riff[8 * i +: 8];
    endfunction

    task automatic send_random_file();
        int kind;
        int idx;
        whp_in_t item;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            // noise with random file starts
            file_stream.delete();
            repeat ($urandom_range(1, 30)) begin
                item.data_byte     = 8'($urandom);
                item.start_of_file = (file_stream.size() == 0) || ($urandom_range(0, 7) == 0);
                file_stream.push_back(item);
            end
        end else begin
            build_wave_file();
            if (kind <= 3) begin
                // break a tag or a field
                idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 11)
                                                  : $urandom_range(0, file_stream.size() - 1);
                file_stream[idx].data_byte ^= 8'($urandom_range(1, 255));
            end else if (kind <= 5) begin
                // cut the file short; the next one restarts the parse
                idx = $urandom_range(1, file_stream.size() - 1);
                while (file_stream.size() > idx)
                    void'(file_stream.pop_back());
            end
            // trailing bytes after the header are ignored
            repeat ($urandom_range(0, 3))
                push_le($urandom, 1);
        end
        send_stream();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_bad_riff_tag();
        file_stream.delete();
        push_le(32'h58464952, 4);
        push_le(32'h0000_00FF, 1);
        send_stream();
    endtask

    task automatic test_bad_wave_tag();
        file_stream.delete();
        push_le(TAG_RIFF, 4);
        push_le(32'hFFFF_FFFF, 4);
        push_le(TAG_WAVE ^ 32'h8000_0000, 4);
        send_stream();
    endtask

    task automatic test_minimal_data_chunk();
        file_stream.delete();
        push_le(TAG_RIFF, 4);
        push_le(32'h0000_0000, 4);
        push_le(TAG_WAVE, 4);
        push_le(TAG_DATA, 4);
        push_le(32'hFFFF_FFFF, 4);
        send_stream();
    endtask

    task automatic test_random_files(int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
            send_random_file();
    endtask

    // Hold the result side off while short bad files keep arriving
    task automatic test_result_backpressure();
        long_hold_req = 1'b1;
        repeat (8) begin
            file_stream.delete();
            push_le($urandom & 32'hFFFF_FF00, 4);
            send_stream();
        end
        while (!long_hold_done) @(negedge aclk);
        long_hold_req = 1'b0;
    endtask

    // Stop sending until every expected header has arrived
    task automatic test_sender_pause();
        pause_sender();
        while (expected_headers.size() != 0) @(negedge aclk);
        build_wave_file();
        send_stream();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        clear_parser();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_bad_riff_tag();
        test_bad_wave_tag();
        test_minimal_data_chunk();
        test_random_files(1450);
        test_result_backpressure();
        test_sender_pause();
        no_idle = 1'b1;
        test_random_files(420);

        // Drain outstanding headers, then watch for stray results
        pause_sender();
        while (expected_headers.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("PASS wave_header_parser");
        else
            $display("FAIL wave_header_parser");
        $finish;
    end

endmodule
